// ----- rtl/ctce_pkg.sv -----
// shared types and codes for the text console cursor engine
`timescale 1ns / 1ps

package ctce_pkg;

  // command codes on the result channel
  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_FILL   = 2'd2;

  // input operation codes
  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [6:0] GLYPH_SPACE = 7'd32;
  localparam logic [6:0] GLYPH_NONE  = 7'd0;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_LEFT = 3'd0;
  localparam logic [2:0] REG_ORIGIN_TOP  = 3'd1;
  localparam logic [2:0] REG_COLUMNS     = 3'd2;
  localparam logic [2:0] REG_ROWS        = 3'd3;
  localparam logic [2:0] REG_INK         = 3'd4;
  localparam logic [2:0] REG_PAPER       = 3'd5;

  // cell position widths cover the largest supported region
  localparam int ENTRY_COL_W = 8;
  localparam int ENTRY_ROW_W = 7;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [ENTRY_COL_W-1:0] col;
    logic [ENTRY_ROW_W-1:0] row;
    logic [6:0]             glyph;
    logic                   last;
  } cmd_entry_t;

endpackage

// ----- rtl/ctce_front.sv -----
// front end: accepts items, tracks the cursor and issues cell commands
`timescale 1ns / 1ps

module ctce_front #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int TAB_SPACES  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_op,
  input  logic [7:0]                             in_char_code,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]       eff_cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]          eff_rows,
  input  logic                                   q_full,
  output logic                                   push,
  output ctce_pkg::cmd_entry_t                   push_entry
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ECW   = $clog2(MAX_COLUMNS + 1);
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int TAB_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
  localparam int XCW   = ctce_pkg::ENTRY_COL_W;
  localparam int XRW   = ctce_pkg::ENTRY_ROW_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pend_r, pend_nxt;
  logic [TAB_W-1:0] left_r, left_nxt;

  logic             busy;
  logic             accept;
  logic [COL_W-1:0] cols_last;
  logic [ROW_W-1:0] rows_last;
  logic [COL_W-1:0] col_c;
  logic [ROW_W-1:0] row_c;
  logic             wrap;
  logic             at_bottom;
  logic [COL_W-1:0] adv_col;
  logic [ROW_W-1:0] adv_row;
  logic             adv_scroll;

  assign busy     = pend_r || (left_r != '0);
  assign in_stall = busy || q_full;
  assign accept   = in_valid && !in_stall;

  assign cols_last = COL_W'(eff_cols - ECW'(1));
  assign rows_last = ROW_W'(eff_rows - ERW'(1));

  // cursor pulled back inside a region that may have shrunk
  assign col_c = (ECW'(col_r) >= eff_cols) ? cols_last : col_r;
  assign row_c = (ERW'(row_r) >= eff_rows) ? rows_last : row_r;

  assign wrap       = (col_c == cols_last);
  assign at_bottom  = (row_c == rows_last);
  assign adv_col    = wrap ? '0 : COL_W'(col_c + 1'b1);
  assign adv_row    = (wrap && !at_bottom) ? ROW_W'(row_c + 1'b1) : row_c;
  assign adv_scroll = wrap && at_bottom;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    pend_nxt   = pend_r;
    left_nxt   = left_r;
    push       = 1'b0;
    push_entry.cmd   = ctce_pkg::CMD_DRAW;
    push_entry.col   = XCW'(col_c);
    push_entry.row   = XRW'(row_c);
    push_entry.glyph = ctce_pkg::GLYPH_SPACE;
    push_entry.last  = 1'b0;
    if (busy) begin
      if (!q_full) begin
        push = 1'b1;
        if (pend_r) begin
          push_entry.cmd   = ctce_pkg::CMD_SCROLL;
          push_entry.col   = '0;
          push_entry.row   = '0;
          push_entry.glyph = ctce_pkg::GLYPH_NONE;
          push_entry.last  = (left_r == '0);
          pend_nxt         = 1'b0;
        end else begin
          // next space of a tab
          push_entry.last = !adv_scroll && (left_r == TAB_W'(1));
          left_nxt        = TAB_W'(left_r - 1'b1);
          col_nxt         = adv_col;
          row_nxt         = adv_row;
          pend_nxt        = adv_scroll;
        end
      end
    end else if (accept) begin
      col_nxt = col_c;
      row_nxt = row_c;
      if (in_op == ctce_pkg::OP_CLEAR) begin
        push             = 1'b1;
        push_entry.cmd   = ctce_pkg::CMD_FILL;
        push_entry.col   = '0;
        push_entry.row   = '0;
        push_entry.glyph = ctce_pkg::GLYPH_NONE;
        push_entry.last  = 1'b1;
        col_nxt          = '0;
        row_nxt          = '0;
      end else begin
        case (in_char_code)
          ctce_pkg::CH_LF: begin
            col_nxt = '0;
            if (at_bottom) begin
              push             = 1'b1;
              push_entry.cmd   = ctce_pkg::CMD_SCROLL;
              push_entry.col   = '0;
              push_entry.row   = '0;
              push_entry.glyph = ctce_pkg::GLYPH_NONE;
              push_entry.last  = 1'b1;
            end else begin
              row_nxt = ROW_W'(row_c + 1'b1);
            end
          end
          ctce_pkg::CH_CR: begin
            col_nxt = '0;
          end
          ctce_pkg::CH_BS: begin
            if (col_c != '0) begin
              col_nxt = COL_W'(col_c - 1'b1);
            end else if (row_c != '0) begin
              col_nxt = cols_last;
              row_nxt = ROW_W'(row_c - 1'b1);
            end
            push            = 1'b1;
            push_entry.col  = XCW'(col_nxt);
            push_entry.row  = XRW'(row_nxt);
            push_entry.last = 1'b1;
          end
          ctce_pkg::CH_TAB: begin
            push            = 1'b1;
            push_entry.last = !adv_scroll && (TAB_SPACES == 1);
            col_nxt         = adv_col;
            row_nxt         = adv_row;
            pend_nxt        = adv_scroll;
            left_nxt        = TAB_W'(TAB_SPACES - 1);
          end
          default: begin
            push             = 1'b1;
            push_entry.glyph = in_char_code[6:0];
            push_entry.last  = !adv_scroll;
            col_nxt          = adv_col;
            row_nxt          = adv_row;
            pend_nxt         = adv_scroll;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= 1'b0;
      left_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ----- rtl/ctce_queue.sv -----
// short command queue between front and back
`timescale 1ns / 1ps

module ctce_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == (PTR_W+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = (PTR_W+1)'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = (PTR_W+1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/ctce_back.sv -----
// back end: turns cell commands into pixel commands in the output register
`timescale 1ns / 1ps

module ctce_back #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16,
  parameter int MAX_COLUMNS  = 128,
  parameter int MAX_ROWS     = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  ctce_pkg::cmd_entry_t              q_entry,
  output logic                              q_pop,
  input  logic [11:0]                       origin_left,
  input  logic [11:0]                       origin_top,
  input  logic [31:0]                       ink_color,
  input  logic [31:0]                       paper_color,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]  eff_cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     eff_rows,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_command,
  output logic [12:0]                       out_pixel_x,
  output logic [12:0]                       out_pixel_y,
  output logic [10:0]                       out_region_width,
  output logic [10:0]                       out_region_height,
  output logic [6:0]                        out_glyph,
  output logic [31:0]                       out_fore_color,
  output logic [31:0]                       out_back_color,
  output logic                              out_last
);

  logic        out_valid_r, out_valid_nxt;
  logic        load;
  logic [1:0]  command_r;
  logic [12:0] pixel_x_r;
  logic [12:0] pixel_y_r;
  logic [10:0] region_width_r;
  logic [10:0] region_height_r;
  logic [6:0]  glyph_r;
  logic [31:0] fore_color_r;
  logic [31:0] back_color_r;
  logic        last_r;

  logic [12:0] px;
  logic [12:0] py;
  logic [13:0] wide_w;
  logic [13:0] wide_h;
  logic [10:0] reg_w;
  logic [10:0] reg_h;

  // scroll and fill entries carry cell zero, so they land on the origin
  assign px = 13'(origin_left) + 13'(13'(q_entry.col) * 13'(GLYPH_WIDTH));
  assign py = 13'(origin_top) + 13'(13'(q_entry.row) * 13'(GLYPH_HEIGHT));

  assign wide_w = 14'(14'(eff_cols) * 14'(GLYPH_WIDTH));
  assign wide_h = 14'(14'(eff_rows) * 14'(GLYPH_HEIGHT));
  assign reg_w  = (wide_w > 14'd2047) ? 11'd2047 : wide_w[10:0];
  assign reg_h  = (wide_h > 14'd2047) ? 11'd2047 : wide_h[10:0];

  assign load  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command_r       <= q_entry.cmd;
      pixel_x_r       <= px;
      pixel_y_r       <= py;
      region_width_r  <= reg_w;
      region_height_r <= reg_h;
      glyph_r         <= q_entry.glyph;
      fore_color_r    <= (q_entry.cmd == ctce_pkg::CMD_DRAW) ? ink_color : '0;
      back_color_r    <= paper_color;
      last_r          <= q_entry.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command       = command_r;
  assign out_pixel_x       = pixel_x_r;
  assign out_pixel_y       = pixel_y_r;
  assign out_region_width  = region_width_r;
  assign out_region_height = region_height_r;
  assign out_glyph         = glyph_r;
  assign out_fore_color    = fore_color_r;
  assign out_back_color    = back_color_r;
  assign out_last          = last_r;

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// top level: configuration registers, front end, command queue and back end
// the first result of an item is registered in the command queue, then in the output register
// throughput: one item per cycle when each item gives at most one command, unless the queue is full
// a glyph that wraps into a scroll, or a tab, holds off further items until its commands are issued
// the front end issues one command per cycle into a four-entry queue, unless the queue is full
// reset: cursor at home, queue and output empty, registers at their defaults
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16,
  parameter int MAX_COLUMNS  = 128,
  parameter int MAX_ROWS     = 64,
  parameter int TAB_SPACES   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic [12:0] out_pixel_x,
  output logic [12:0] out_pixel_y,
  output logic [10:0] out_region_width,
  output logic [10:0] out_region_height,
  output logic [6:0]  out_glyph,
  output logic [31:0] out_fore_color,
  output logic [31:0] out_back_color,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ECW = $clog2(MAX_COLUMNS + 1);
  localparam int ERW = $clog2(MAX_ROWS + 1);

  logic [11:0] origin_left_r;
  logic [11:0] origin_top_r;
  logic [7:0]  columns_r;
  logic [6:0]  rows_r;
  logic [31:0] ink_color_r;
  logic [31:0] paper_color_r;

  logic [8:0]     cols_w;
  logic [7:0]     rows_w;
  logic [ECW-1:0] eff_cols;
  logic [ERW-1:0] eff_rows;

  logic                 push;
  ctce_pkg::cmd_entry_t push_entry;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  ctce_pkg::cmd_entry_t q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_left_r <= '0;
      origin_top_r  <= '0;
      columns_r     <= 8'd80;
      rows_r        <= 7'd25;
      ink_color_r   <= 32'hFFFF_FFFF;
      paper_color_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctce_pkg::REG_ORIGIN_LEFT: origin_left_r <= cfg_data[11:0];
        ctce_pkg::REG_ORIGIN_TOP:  origin_top_r  <= cfg_data[11:0];
        ctce_pkg::REG_COLUMNS:     columns_r     <= cfg_data[7:0];
        ctce_pkg::REG_ROWS:        rows_r        <= cfg_data[6:0];
        ctce_pkg::REG_INK:         ink_color_r   <= cfg_data;
        ctce_pkg::REG_PAPER:       paper_color_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts clamped to one through the maximum
  assign cols_w = {1'b0, columns_r};
  assign rows_w = {1'b0, rows_r};
  assign eff_cols = (cols_w == '0) ? ECW'(1) :
                    (cols_w > 9'(MAX_COLUMNS)) ? ECW'(MAX_COLUMNS) : ECW'(cols_w);
  assign eff_rows = (rows_w == '0) ? ERW'(1) :
                    (rows_w > 8'(MAX_ROWS)) ? ERW'(MAX_ROWS) : ERW'(rows_w);

  ctce_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TAB_SPACES  (TAB_SPACES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .eff_cols     (eff_cols),
    .eff_rows     (eff_rows),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  ctce_queue #(
    .W ($bits(ctce_pkg::cmd_entry_t))
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .empty     (q_empty)
  );

  ctce_back #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_entry           (q_entry),
    .q_pop             (q_pop),
    .origin_left       (origin_left_r),
    .origin_top        (origin_top_r),
    .ink_color         (ink_color_r),
    .paper_color       (paper_color_r),
    .eff_cols          (eff_cols),
    .eff_rows          (eff_rows),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command       (out_command),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_region_width  (out_region_width),
    .out_region_height (out_region_height),
    .out_glyph         (out_glyph),
    .out_fore_color    (out_fore_color),
    .out_back_color    (out_back_color),
    .out_last          (out_last)
  );

endmodule

// ----- sim/tb_text_console_cursor_engine.sv -----
// self-checking testbench for the text console cursor engine
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;

  localparam int CELL_W      = 8;
  localparam int CELL_H      = 16;
  localparam int MAX_COLS    = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_WIDTH   = 4;
  localparam int MAX_CMDS    = 8;
  localparam int SETTLE      = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 55;

  // indexes outside the register list, writes there must be ignored
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [10:0] region_width;
    logic [10:0] region_height;
    logic [6:0]  glyph;
    logic [31:0] fore_color;
    logic [31:0] back_color;
    logic        last;
  } console_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_command;
  logic [12:0] out_pixel_x;
  logic [12:0] out_pixel_y;
  logic [10:0] out_region_width;
  logic [10:0] out_region_height;
  logic [6:0]  out_glyph;
  logic [31:0] out_fore_color;
  logic [31:0] out_back_color;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // shadow registers and cursor
  logic [11:0] sh_left  = '0;
  logic [11:0] sh_top   = '0;
  logic [7:0]  sh_cols  = 8'd80;
  logic [6:0]  sh_rows  = 7'd25;
  logic [31:0] sh_ink   = 32'hFFFF_FFFF;
  logic [31:0] sh_paper = '0;
  logic [6:0]  cur_col  = '0;
  logic [5:0]  cur_row  = '0;

  console_cmd_t item_cmds[$];
  console_cmd_t expected_cmds[$];

  int n_items, n_cfg_writes, n_draw, n_scroll, n_fill, n_errors, idle_cycles;
  int hold_len;
  bit in_gaps_on, out_gaps_on;

  text_console_cursor_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_region_width (out_region_width),
    .out_region_height(out_region_height),
    .out_glyph        (out_glyph),
    .out_fore_color   (out_fore_color),
    .out_back_color   (out_back_color),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] cols_in_use();
    if (sh_cols == 8'd0) return 8'd1;
    if (sh_cols > MAX_COLS) return 8'(MAX_COLS);
    return sh_cols;
  endfunction

  function automatic logic [6:0] rows_in_use();
    if (sh_rows == 7'd0) return 7'd1;
    if (sh_rows > MAX_ROWS) return 7'(MAX_ROWS);
    return sh_rows;
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, int px, int py, logic [6:0] g,
                                    logic [31:0] fg, logic [31:0] bg);
    console_cmd_t c;
    int w, h;
    // commands past the limit are dropped, the cursor still moves
    if (item_cmds.size() >= MAX_CMDS) return;
    w = cols_in_use() * CELL_W;
    h = rows_in_use() * CELL_H;
    c.command       = cmd;
    c.pixel_x       = px[12:0];
    c.pixel_y       = py[12:0];
    c.region_width  = (w > 2047) ? 11'd2047 : w[10:0];
    c.region_height = (h > 2047) ? 11'd2047 : h[10:0];
    c.glyph         = g;
    c.fore_color    = fg;
    c.back_color    = bg;
    c.last          = 1'b0;
    item_cmds.push_back(c);
  endfunction

  function automatic void draw_cell(logic [6:0] g);
    queue_cmd(ctce_pkg::CMD_DRAW, sh_left + cur_col * CELL_W, sh_top + cur_row * CELL_H,
              g, sh_ink, sh_paper);
  endfunction

  function automatic void new_line();
    logic [6:0] nxt;
    logic [6:0] bottom;
    cur_col = '0;
    nxt = {1'b0, cur_row} + 7'd1;
    if (nxt >= rows_in_use()) begin
      queue_cmd(ctce_pkg::CMD_SCROLL, sh_left, sh_top, ctce_pkg::GLYPH_NONE, '0, sh_paper);
      bottom = rows_in_use() - 7'd1;
      cur_row = bottom[5:0];
    end else begin
      cur_row = nxt[5:0];
    end
  endfunction

  function automatic void put_glyph(logic [6:0] g);
    logic [7:0] nxt;
    draw_cell(g);
    nxt = {1'b0, cur_col} + 8'd1;
    if (nxt >= cols_in_use()) new_line();
    else cur_col = nxt[6:0];
  endfunction

  function automatic void predict_item(logic op, logic [7:0] code);
    logic [7:0] edge_col;
    logic [6:0] edge_row;
    item_cmds.delete();
    // a shrunken region pulls the cursor back inside
    edge_col = cols_in_use() - 8'd1;
    edge_row = rows_in_use() - 7'd1;
    if ({1'b0, cur_col} > edge_col) cur_col = edge_col[6:0];
    if ({1'b0, cur_row} > edge_row) cur_row = edge_row[5:0];
    if (op == ctce_pkg::OP_CLEAR) begin
      queue_cmd(ctce_pkg::CMD_FILL, sh_left, sh_top, ctce_pkg::GLYPH_NONE, '0, sh_paper);
      cur_col = '0;
      cur_row = '0;
    end else begin
      case (code)
        ctce_pkg::CH_LF: new_line();
        ctce_pkg::CH_CR: cur_col = '0;
        ctce_pkg::CH_TAB: begin
          for (int i = 0; i < TAB_WIDTH; i++) put_glyph(ctce_pkg::GLYPH_SPACE);
        end
        ctce_pkg::CH_BS: begin
          if (cur_col != '0) begin
            cur_col = cur_col - 7'd1;
          end else if (cur_row != '0) begin
            cur_row = cur_row - 6'd1;
            cur_col = edge_col[6:0];
          end
          draw_cell(ctce_pkg::GLYPH_SPACE);
        end
        default: put_glyph(code[6:0]);
      endcase
    end
    if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
    foreach (item_cmds[i]) expected_cmds.push_back(item_cmds[i]);
  endfunction

  function automatic void note_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      ctce_pkg::REG_ORIGIN_LEFT: sh_left  = data[11:0];
      ctce_pkg::REG_ORIGIN_TOP:  sh_top   = data[11:0];
      ctce_pkg::REG_COLUMNS:     sh_cols  = data[7:0];
      ctce_pkg::REG_ROWS:        sh_rows  = data[6:0];
      ctce_pkg::REG_INK:         sh_ink   = data;
      ctce_pkg::REG_PAPER:       sh_paper = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string cmd_text(console_cmd_t c);
    return $sformatf("cmd=%0d x=%0d y=%0d w=%0d h=%0d glyph=%0d fg=%h bg=%h last=%0d",
                     c.command, c.pixel_x, c.pixel_y, c.region_width, c.region_height,
                     c.glyph, c.fore_color, c.back_color, c.last);
  endfunction

  function automatic void check_cmd(console_cmd_t got);
    console_cmd_t want;
    string bad;
    if (expected_cmds.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected command: %s", cmd_text(got));
      return;
    end
    want = expected_cmds.pop_front();
    case (want.command)
      ctce_pkg::CMD_DRAW:   n_draw++;
      ctce_pkg::CMD_SCROLL: n_scroll++;
      default:              n_fill++;
    endcase
    bad = "";
    if (got.command !== want.command)             bad = {bad, " command"};
    if (got.pixel_x !== want.pixel_x)             bad = {bad, " pixel_x"};
    if (got.pixel_y !== want.pixel_y)             bad = {bad, " pixel_y"};
    if (got.region_width !== want.region_width)   bad = {bad, " region_width"};
    if (got.region_height !== want.region_height) bad = {bad, " region_height"};
    if (got.glyph !== want.glyph)                 bad = {bad, " glyph"};
    if (got.fore_color !== want.fore_color)       bad = {bad, " fore_color"};
    if (got.back_color !== want.back_color)       bad = {bad, " back_color"};
    if (got.last !== want.last)                   bad = {bad, " last"};
    if (bad != "") begin
      n_errors++;
      if (n_errors <= 10) begin
        $display("mismatch in%s", bad);
        $display("  expected %s", cmd_text(want));
        $display("  actual   %s", cmd_text(got));
      end
    end
  endfunction

  // one process sees every handshake, so prediction and checking keep edge order
  always @(posedge clk) begin : handshake_monitor
    bit moved;
    console_cmd_t got;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready === 1'b1) begin
        note_register(cfg_index, cfg_data);
        n_cfg_writes++;
        moved = 1'b1;
      end
      if (in_valid && in_stall === 1'b0) begin
        predict_item(in_op, in_char_code);
        n_items++;
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        got.command       = out_command;
        got.pixel_x       = out_pixel_x;
        got.pixel_y       = out_pixel_y;
        got.region_width  = out_region_width;
        got.region_height = out_region_height;
        got.glyph         = out_glyph;
        got.fore_color    = out_fore_color;
        got.back_color    = out_back_color;
        got.last          = out_last;
        check_cmd(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles, %0d commands still due",
             IDLE_LIMIT, expected_cmds.size());
    $display("text_console_cursor_engine verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // receiver side stalls
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else begin
        n = out_gaps_on ? pick_gap() : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // valid is left high on return so the next item can follow back to back
  task automatic send_char(input logic op, input logic [7:0] code);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_char_code <= code;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic send_random_char();
    int r;
    r = $urandom_range(99);
    if (r < 3)       send_char(ctce_pkg::OP_CLEAR, 8'($urandom_range(255)));
    else if (r < 13) send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_LF);
    else if (r < 18) send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_CR);
    else if (r < 24) send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_TAB);
    else if (r < 32) send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_BS);
    else             send_char(ctce_pkg::OP_PUT, 8'($urandom_range(255)));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // narrow registers get random upper bits, which the block must drop
  task automatic apply_config(input logic [11:0] left, input logic [11:0] top,
                              input logic [7:0] cols, input logic [6:0] rows,
                              input logic [31:0] ink, input logic [31:0] paper);
    wait_drain();
    // items with no command may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_write(ctce_pkg::REG_ORIGIN_LEFT, ($urandom() & 32'hFFFF_F000) | left);
    cfg_write(ctce_pkg::REG_ORIGIN_TOP,  ($urandom() & 32'hFFFF_F000) | top);
    cfg_write(ctce_pkg::REG_COLUMNS,     ($urandom() & 32'hFFFF_FF00) | cols);
    cfg_write(ctce_pkg::REG_ROWS,        ($urandom() & 32'hFFFF_FF80) | rows);
    cfg_write(ctce_pkg::REG_INK,         ink);
    cfg_write(ctce_pkg::REG_PAPER,       paper);
  endtask

  // ---------------------------------------------------------------- tests

  // reset region, every control character and the glyph mask
  task automatic test_control_chars();
    send_char(ctce_pkg::OP_PUT, 8'h41);
    send_char(ctce_pkg::OP_PUT, 8'h00);
    send_char(ctce_pkg::OP_PUT, 8'hFF);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_TAB);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_BS);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_CR);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_LF);
    // column 0 of row 1 steps back to the end of row 0
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_BS);
    send_char(ctce_pkg::OP_CLEAR, 8'hA5);
    // backspace at home blanks the home cell
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_BS);
    wait_drain();
  endtask

  task automatic test_region_extremes();
    apply_config(12'hFFF, 12'hFFF, 8'd128, 7'd64, 32'h0, 32'hFFFF_FFFF);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_TAB);
    send_char(ctce_pkg::OP_PUT, 8'h7F);
    // one cell region: a tab gives a draw and a scroll per space
    apply_config(12'h0, 12'h0, 8'd1, 7'd1, $urandom(), $urandom());
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_TAB);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_LF);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_BS);
    // zero counts clamp up to one
    apply_config(12'($urandom()), 12'($urandom()), 8'd0, 7'd0, $urandom(), $urandom());
    send_char(ctce_pkg::OP_PUT, 8'h51);
    // counts beyond the maximum clamp down
    apply_config(12'($urandom()), 12'($urandom()), 8'hFF, 7'h7F, $urandom(), $urandom());
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_TAB);
    wait_drain();
  endtask

  // move the cursor out, then shrink the region under it
  task automatic test_shrunken_region();
    apply_config(12'($urandom()), 12'($urandom()), 8'd80, 7'd25, $urandom(), $urandom());
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_LF);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_LF);
    send_char(ctce_pkg::OP_PUT, 8'h61);
    send_char(ctce_pkg::OP_PUT, 8'h62);
    apply_config(12'($urandom()), 12'($urandom()), 8'd2, 7'd2, $urandom(), $urandom());
    send_char(ctce_pkg::OP_PUT, 8'h64);
    send_char(ctce_pkg::OP_PUT, ctce_pkg::CH_BS);
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_holdoff();
    apply_config(12'($urandom()), 12'($urandom()), 8'd3, 7'd2, $urandom(), $urandom());
    in_gaps_on = 1'b0;
    hold_len = HOLD_CYCLES;
    repeat (30) send_random_char();
    in_gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_back_to_back();
    apply_config(12'($urandom()), 12'($urandom()), 8'd2, 7'd2, $urandom(), $urandom());
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (30) send_random_char();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_regions();
    logic [7:0] cols;
    logic [6:0] rows;
    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(3) == 0) begin
        cols = 8'($urandom_range(255));
        rows = 7'($urandom_range(127));
      end else begin
        cols = 8'($urandom_range(1, 12));
        rows = 7'($urandom_range(1, 6));
      end
      apply_config(12'($urandom()), 12'($urandom()), cols, rows, $urandom(), $urandom());
      cfg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      repeat (PHASE_ITEMS) send_random_char();
    end
    wait_drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= ctce_pkg::OP_PUT;
    in_char_code <= '0;
    out_stall    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= ctce_pkg::REG_ORIGIN_LEFT;
    cfg_data     <= '0;
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_control_chars();
    test_region_extremes();
    test_shrunken_region();
    test_output_holdoff();
    test_back_to_back();
    test_random_regions();

    wait_drain();
    repeat (SETTLE + 4) @(posedge clk);
    $display("covered %0d items and %0d register writes, regions from one cell to 128x64",
             n_items, n_cfg_writes);
    $display("commands checked: %0d draw, %0d scroll, %0d fill, %0d mismatches",
             n_draw, n_scroll, n_fill, n_errors);
    if (n_errors == 0 && expected_cmds.size() == 0) begin
      $display("text_console_cursor_engine verification clean");
    end else begin
      $display("text_console_cursor_engine verification failed");
    end
    $finish;
  end

endmodule
